### hdl/ceat_pkg.sv
package ceat_pkg;

  localparam int LEN_W    = 20;
  localparam int TIER_W   = 3;
  localparam int DEP_W    = 36;
  localparam int ARR_W    = 37;
  localparam int TT_W     = 26;
  localparam int CFG_W    = 16;
  localparam int DAY_W    = 21;
  localparam int HOUR_W   = 5;
  localparam int RIH_W    = 16;
  localparam int MULT_W   = 12;
  localparam int M20_W    = 22;
  localparam int LXI_W    = LEN_W + CFG_W;

  localparam int NUM_TIERS_DEF = 5;

  localparam int DS_STAGES   = 3;
  localparam int TR_STAGES   = 8;
  localparam int PIPE_STAGES = DS_STAGES + TR_STAGES + 1;

  localparam logic [DAY_W-1:0] DAY_TICKS  = 21'd1382400;
  localparam logic [15:0]      HOUR_TICKS = 16'd57600;
  localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;

  // day = 2^11 * 675, hour = 2^8 * 225, m20 = (8*mnum + 225) / 450
  localparam logic [9:0]  DAY_ODD     = 10'd675;
  localparam logic [24:0] DAY_RECIP   = 25'd25451658;
  localparam int          DAY_SHIFT   = 34;
  localparam logic [7:0]  HOUR_ODD    = 8'd225;
  localparam logic [12:0] HOUR_RECIP  = 13'd4660;
  localparam int          HOUR_SHIFT  = 20;
  localparam logic [8:0]  M20_DIV     = 9'd450;
  localparam logic [31:0] M20_RECIP   = 32'd2443359172;
  localparam int          M20_SHIFT   = 40;
  localparam logic [7:0]  M20_BIAS    = 8'd225;

  localparam logic [CFG_W-1:0] INV_SPEED_RST = 16'd5904;
  localparam logic [CFG_W-1:0] FIFO_STEP_RST = 16'd960;

  localparam int  PADDR_W       = 3;
  localparam int  PDATA_W       = 32;
  localparam logic REG_INV_SPEED = 1'b0;
  localparam logic REG_FIFO_STEP = 1'b1;

  localparam int ONE_Q10 = 1024;

  localparam logic [MULT_W-1:0] ART_Q10 [24] = '{
    12'd1024, 12'd1024, 12'd1024, 12'd1024, 12'd1044, 12'd1126,
    12'd1382, 12'd1843, 12'd2406, 12'd2611, 12'd2099, 12'd1741,
    12'd1587, 12'd1587, 12'd1536, 12'd1638, 12'd1894, 12'd2355,
    12'd2662, 12'd2458, 12'd1946, 12'd1536, 12'd1280, 12'd1106
  };

endpackage

### hdl/ceat_if.sv
interface ceat_in_if;
  import ceat_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  edge_length;
  logic [TIER_W-1:0] congestion_tier;
  logic [DEP_W-1:0]  departure_time;

  modport source (output valid, edge_length, congestion_tier, departure_time, input ready);
  modport sink (input valid, edge_length, congestion_tier, departure_time, output ready);
endinterface

interface ceat_out_if;
  import ceat_pkg::*;
  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] arrival_time;
  logic [TT_W-1:0]  edge_travel_time;

  modport source (output valid, arrival_time, edge_travel_time, input ready);
  modport sink (input valid, arrival_time, edge_travel_time, output ready);
endinterface

### hdl/ceat_pipe_ctrl.sv
module ceat_pipe_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             out_ready,
  output logic                             in_ready,
  output logic                             out_valid,
  output logic [ceat_pkg::PIPE_STAGES-1:0] en
);
  import ceat_pkg::*;

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;

  assign en[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || out_ready;

  for (genvar k = 0; k < PIPE_STAGES - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign v_nxt[0] = en[0] ? in_valid : v_r[0];
  for (genvar k = 1; k < PIPE_STAGES; k++) begin : g_v
    assign v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[PIPE_STAGES-1];

endmodule

### hdl/ceat_day_split.sv
module ceat_day_split (
  input  logic                           clk,
  input  logic [ceat_pkg::DS_STAGES-1:0] en,
  input  logic [ceat_pkg::DEP_W-1:0]     dep,
  input  logic [ceat_pkg::CFG_W-1:0]     fifo_step,
  output logic [ceat_pkg::DAY_W-1:0]     day_now,
  output logic [ceat_pkg::DAY_W-1:0]     day_early,
  output logic [ceat_pkg::DEP_W-1:0]     dep_out
);
  import ceat_pkg::*;

  localparam int HI_W = DEP_W - 11;

  logic [HI_W+DAY_SHIFT-10:0] dprod;
  logic [15:0]                dq_r;
  logic [DEP_W-1:0]           dep1_r, dep2_r, dep3_r;
  logic [HI_W:0]              dsub;
  logic [10:0]                drem;
  logic [9:0]                 drem_c;
  logic [DAY_W-1:0]           dnow2_r, dnow3_r, dearly_r;
  logic [DAY_W-1:0]           dstep;

  assign dprod = 50'(dep[DEP_W-1:11]) * 50'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dq_r   <= dprod[DAY_SHIFT+15:DAY_SHIFT];
      dep1_r <= dep;
    end
  end

  assign dsub   = {1'b0, dep1_r[DEP_W-1:11]} - (26'(dq_r) * 26'(DAY_ODD));
  assign drem   = dsub[10:0];
  assign drem_c = (drem >= 11'(DAY_ODD)) ? 10'(drem - 11'(DAY_ODD)) : drem[9:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dnow2_r <= {drem_c, dep1_r[10:0]};
      dep2_r  <= dep1_r;
    end
  end

  assign dstep = DAY_W'(fifo_step);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dnow3_r  <= dnow2_r;
      dearly_r <= (dnow2_r >= dstep) ? dnow2_r - dstep : dnow2_r + (DAY_TICKS - dstep);
      dep3_r   <= dep2_r;
    end
  end

  assign day_now   = dnow3_r;
  assign day_early = dearly_r;
  assign dep_out   = dep3_r;

endmodule

### hdl/ceat_travel.sv
module ceat_travel #(
  parameter int NUM_TIERS = ceat_pkg::NUM_TIERS_DEF
) (
  input  logic                           clk,
  input  logic [ceat_pkg::TR_STAGES-1:0] en,
  input  logic [ceat_pkg::DAY_W-1:0]     day_time,
  input  logic [$clog2(NUM_TIERS)-1:0]   tier,
  input  logic [ceat_pkg::LXI_W-1:0]     lxi,
  output logic [ceat_pkg::TT_W-1:0]      travel
);
  import ceat_pkg::*;

  localparam int TW  = $clog2(NUM_TIERS);
  localparam int DEN = NUM_TIERS - 1;
  localparam int LH  = LXI_W / 2;

  logic [MULT_W-1:0] blend_tab [24][NUM_TIERS];

  for (genvar h = 0; h < 24; h++) begin : g_h
    for (genvar t = 0; t < NUM_TIERS; t++) begin : g_t
      localparam int EX = int'(ART_Q10[h]) - ONE_Q10;
      localparam int BV = ONE_Q10 + (EX * t * 2 + DEN) / (2 * DEN);
      assign blend_tab[h][t] = MULT_W'(BV);
    end
  end

  // T1: hour estimate
  logic [25:0]       hprod;
  logic [4:0]        hq_r;
  logic [12:0]       y_r;
  logic [7:0]        lo8_r;
  logic [TW-1:0]     tier1_r, tier2_r;
  logic [LXI_W-1:0]  lxi1_r, lxi2_r, lxi3_r, lxi4_r, lxi5_r, lxi6_r;

  assign hprod = 26'(day_time[DAY_W-1:8]) * 26'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hq_r    <= hprod[HOUR_SHIFT+4:HOUR_SHIFT];
      y_r     <= day_time[DAY_W-1:8];
      lo8_r   <= day_time[7:0];
      tier1_r <= tier;
      lxi1_r  <= lxi;
    end
  end

  // T2: hour and time within hour
  logic [12:0]       hsub;
  logic [8:0]        ry;
  logic              hfix;
  logic [HOUR_W-1:0] hour_r;
  logic [RIH_W-1:0]  rih_r;
  logic [7:0]        rih_hi;

  assign hsub   = y_r - (13'(hq_r) * 13'(HOUR_ODD));
  assign ry     = hsub[8:0];
  assign hfix   = ry >= 9'(HOUR_ODD);
  assign rih_hi = hfix ? 8'(ry - 9'(HOUR_ODD)) : ry[7:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hour_r  <= hfix ? hq_r + 5'd1 : hq_r;
      rih_r   <= {rih_hi, lo8_r};
      tier2_r <= tier1_r;
      lxi2_r  <= lxi1_r;
    end
  end

  // T3: blended multipliers, slope times offset
  logic [HOUR_W-1:0]  next_hour;
  logic [MULT_W-1:0]  mb, mn;
  logic signed [12:0] mdiff;
  logic signed [29:0] dr_r;
  logic [MULT_W-1:0]  b_r;

  assign next_hour = (hour_r == LAST_HOUR) ? '0 : hour_r + 5'd1;
  assign mb        = blend_tab[hour_r][tier2_r];
  assign mn        = blend_tab[next_hour][tier2_r];
  assign mdiff     = $signed({1'b0, mn}) - $signed({1'b0, mb});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dr_r   <= 30'(mdiff * $signed({1'b0, rih_r}));
      b_r    <= mb;
      lxi3_r <= lxi2_r;
    end
  end

  // T4: weighted sum
  logic [27:0]        bh;
  logic signed [29:0] mnum;
  logic [30:0]        x3_r;

  assign bh   = 28'(b_r) * 28'(HOUR_TICKS);
  assign mnum = $signed({2'b00, bh}) + dr_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x3_r   <= {mnum[27:0], 3'b000} + 31'(M20_BIAS);
      lxi4_r <= lxi3_r;
    end
  end

  // T5: quotient estimate
  logic [62:0]       qprod;
  logic [M20_W-1:0]  qm_r;
  logic [30:0]       x3b_r;

  assign qprod = 63'(x3_r) * 63'(M20_RECIP);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      qm_r   <= qprod[M20_SHIFT+M20_W-1:M20_SHIFT];
      x3b_r  <= x3_r;
      lxi5_r <= lxi4_r;
    end
  end

  // T6: quotient correction
  logic [30:0]      msub;
  logic [M20_W-1:0] m20_r;

  assign msub = x3b_r - (31'(qm_r) * 31'(M20_DIV));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m20_r  <= (msub[9:0] >= 10'(M20_DIV)) ? qm_r + 22'd1 : qm_r;
      lxi6_r <= lxi5_r;
    end
  end

  // T7: partial products
  logic [LH+M20_W-1:0] pp_hi_r, pp_lo_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pp_hi_r <= (LH+M20_W)'(lxi6_r[LXI_W-1:LH]) * (LH+M20_W)'(m20_r);
      pp_lo_r <= (LH+M20_W)'(lxi6_r[LH-1:0]) * (LH+M20_W)'(m20_r);
    end
  end

  // T8: sum, round, saturate
  logic [58:0] psum;
  logic [26:0] tq;
  logic [TT_W-1:0] tt_r;

  assign psum = {1'b0, pp_hi_r, {LH{1'b0}}} + 59'(pp_lo_r) + (59'(1) << 31);
  assign tq   = psum[58:32];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tt_r <= tq[TT_W] ? '1 : tq[TT_W-1:0];
    end
  end

  assign travel = tt_r;

endmodule

### hdl/congested_edge_arrival_time.sv
// Edge travel time and FIFO-safe arrival time for a time-dependent road graph.
// One word is accepted every clock cycle while the output is not stalled. The
// pipeline holds 3 stages that split the departure into the time of day now and
// fifo_step earlier, 8 stages that find the hour and form the interpolated
// multiplier and the product, and 1 stage that makes the FIFO compare and holds
// the output. Two travel units run side by side, one for the departure and one
// for the departure fifo_step earlier. A stalled output holds only the stages
// behind it that are full. Registers on the APB port: inverse_speed at 0x0,
// fifo_step at 0x4; write them only while no word is in flight.
module congested_edge_arrival_time #(
  parameter int NUM_TIERS = ceat_pkg::NUM_TIERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ceat_in_if.sink                       in_ch,
  ceat_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ceat_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [ceat_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [ceat_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import ceat_pkg::*;

  localparam int TW = $clog2(NUM_TIERS);
  localparam int TB = DS_STAGES;
  localparam int FO = PIPE_STAGES - 1;

  logic [CFG_W-1:0] inv_speed_r, fifo_step_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_speed_r <= INV_SPEED_RST;
      fifo_step_r <= FIFO_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_INV_SPEED: inv_speed_r <= cfg_pwdata[CFG_W-1:0];
        REG_FIFO_STEP: fifo_step_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_INV_SPEED: cfg_prdata = PDATA_W'(inv_speed_r);
      REG_FIFO_STEP: cfg_prdata = PDATA_W'(fifo_step_r);
      default:       cfg_prdata = '0;
    endcase
  end

  logic [PIPE_STAGES-1:0] en;

  ceat_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .en        (en)
  );

  // side payload through the day split stages
  logic [TW-1:0]    tier_c;
  logic [TW-1:0]    tier_r [DS_STAGES];
  logic [LXI_W-1:0] lxi_r  [DS_STAGES];

  assign tier_c = (in_ch.congestion_tier > TIER_W'(NUM_TIERS - 1))
                  ? TW'(NUM_TIERS - 1) : in_ch.congestion_tier[TW-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tier_r[0] <= tier_c;
      lxi_r[0]  <= LXI_W'(in_ch.edge_length) * LXI_W'(inv_speed_r);
    end
  end

  for (genvar k = 1; k < DS_STAGES; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        tier_r[k] <= tier_r[k-1];
        lxi_r[k]  <= lxi_r[k-1];
      end
    end
  end

  logic [DAY_W-1:0] day_now, day_early;
  logic [DEP_W-1:0] dep_ds;

  ceat_day_split u_day (
    .clk       (clk),
    .en        (en[DS_STAGES-1:0]),
    .dep       (in_ch.departure_time),
    .fifo_step (fifo_step_r),
    .day_now   (day_now),
    .day_early (day_early),
    .dep_out   (dep_ds)
  );

  logic [TT_W-1:0] tt_now, tt_early;

  ceat_travel #(.NUM_TIERS(NUM_TIERS)) u_tr_now (
    .clk      (clk),
    .en       (en[TB+TR_STAGES-1:TB]),
    .day_time (day_now),
    .tier     (tier_r[DS_STAGES-1]),
    .lxi      (lxi_r[DS_STAGES-1]),
    .travel   (tt_now)
  );

  ceat_travel #(.NUM_TIERS(NUM_TIERS)) u_tr_early (
    .clk      (clk),
    .en       (en[TB+TR_STAGES-1:TB]),
    .day_time (day_early),
    .tier     (tier_r[DS_STAGES-1]),
    .lxi      (lxi_r[DS_STAGES-1]),
    .travel   (tt_early)
  );

  logic [DEP_W-1:0] dep_r [TR_STAGES];

  always_ff @(posedge clk) begin
    if (en[TB]) begin
      dep_r[0] <= dep_ds;
    end
  end

  for (genvar k = 1; k < TR_STAGES; k++) begin : g_dep
    always_ff @(posedge clk) begin
      if (en[TB+k]) begin
        dep_r[k] <= dep_r[k-1];
      end
    end
  end

  logic [ARR_W-1:0] naive, bplus, bminus, arr_nxt;
  logic [ARR_W-1:0] arr_r;
  logic [TT_W-1:0]  tt_r;

  assign naive   = {1'b0, dep_r[TR_STAGES-1]} + ARR_W'(tt_now);
  assign bplus   = {1'b0, dep_r[TR_STAGES-1]} + ARR_W'(tt_early);
  assign bminus  = bplus - ARR_W'(fifo_step_r);
  assign arr_nxt = (bplus >= ARR_W'(fifo_step_r) && bminus > naive) ? bminus : naive;

  always_ff @(posedge clk) begin
    if (en[FO]) begin
      arr_r <= arr_nxt;
      tt_r  <= tt_now;
    end
  end

  assign out_ch.arrival_time     = arr_r;
  assign out_ch.edge_travel_time = tt_r;

  a_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_arr_ge_tt: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.arrival_time >= ARR_W'(out_ch.edge_travel_time))
    else $error("arrival earlier than travel time");

endmodule
